FILE: rtl/dsfe_pkg.sv
// ----------------------------------------------------------------------------
// dsfe_pkg
// Shared types and constants of the four-motor DShot frame encoder.
// ----------------------------------------------------------------------------
package dsfe_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_MOTORS_DEF          = 4;
  localparam int FAILSAFE_TIMEOUT_US_DEF = 100000;

  // Pin lanes on the output beat and packet geometry
  localparam int LANES       = 4;
  localparam int PKT_W       = 16;
  localparam int VAL_W       = 11;
  localparam int BIT_IDX_W   = $clog2(PKT_W);
  localparam int FRAME_SLOTS = PKT_W * 3;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;
  localparam int IDLE_W     = 9;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  // Frame queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Item kinds carried on tuser
  typedef enum logic {
    OP_THROTTLE = 1'b0,
    OP_COMMAND  = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IDLE_OFFSET = 1'b0,
    REG_BIDIR_MODE  = 1'b1
  } reg_e;

  // Direction codes
  localparam logic [1:0] DIR_FORWARD = 2'd0;
  localparam logic [1:0] DIR_REVERSE = 2'd1;

  // Three slots of one packet bit
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_DATA = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // One frame as handed from front to back
  typedef struct packed {
    logic [LANES-1:0]            valid;
    logic [LANES-1:0][PKT_W-1:0] pkt;
  } frame_t;

endpackage

FILE: rtl/dsfe_front.sv
// ----------------------------------------------------------------------------
// dsfe_front
// Accepts items, runs the failsafe timer, maps throttle to a DShot value,
// keeps the per-motor packets and pushes complete frames into the queue.
// ----------------------------------------------------------------------------
module dsfe_front #(
  parameter int NUM_MOTORS          = dsfe_pkg::NUM_MOTORS_DEF,
  parameter int FAILSAFE_TIMEOUT_US = dsfe_pkg::FAILSAFE_TIMEOUT_US_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsfe_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [dsfe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dsfe_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            in_op_i,
  input  logic                            q_ready_i,
  output logic                            q_push_o,
  output dsfe_pkg::frame_t                q_data_o
);

  localparam int VW = dsfe_pkg::VAL_W;
  localparam int PW = 2 * VW - 1;  // throttle x span product

  function automatic logic [dsfe_pkg::PKT_W-1:0] build_packet(
    input logic [VW-1:0] value,
    input logic          telem
  );
    logic [VW:0] p;
    p = {value, telem};
    return {p, p[3:0] ^ p[7:4] ^ p[11:8]};
  endfunction

  // Configuration registers
  logic [dsfe_pkg::IDLE_W-1:0] idle_q;
  logic                        bidir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= dsfe_pkg::IDLE_W'(30);
      bidir_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (dsfe_pkg::reg_e'(cfg_addr_i))
        dsfe_pkg::REG_IDLE_OFFSET: idle_q  <= cfg_data_i[dsfe_pkg::IDLE_W-1:0];
        dsfe_pkg::REG_BIDIR_MODE:  bidir_q <= cfg_data_i[0];
      endcase
    end
  end

  // Unpack the input beat
  logic [1:0]  in_idx;
  logic [9:0]  in_thr;
  logic [1:0]  in_dir;
  logic        in_ground;
  logic        in_fs;
  logic [31:0] in_now;
  logic [VW-1:0] in_cmd;

  assign in_idx    = in_data_i[1:0];
  assign in_thr    = in_data_i[11:2];
  assign in_dir    = in_data_i[13:12];
  assign in_ground = in_data_i[14];
  assign in_fs     = in_data_i[15];
  assign in_now    = in_data_i[47:16];
  assign in_cmd    = in_data_i[58:48];

  // Range span, its upper clamp and base code
  logic [VW-1:0] span, bsub, bmax, base;
  logic [PW-1:0] prod;
  logic          dir_bad;

  always_comb begin
    if (bidir_q) begin
      span = 11'd1000 - VW'(idle_q);
      base = ((in_dir == dsfe_pkg::DIR_REVERSE) ? 11'd1048 : 11'd48) + VW'(idle_q);
    end else begin
      span = 11'd2001 - {1'b0, idle_q, 1'b0};
      base = 11'd48 + {1'b0, idle_q, 1'b0};
    end
    // floor(999*span/1000) is span less ceil(span/1000)
    if (span > 11'd2000)      bsub = 11'd3;
    else if (span > 11'd1000) bsub = 11'd2;
    else                      bsub = 11'd1;
    bmax    = span - bsub;
    prod    = PW'(in_thr) * PW'(span);
    dir_bad = bidir_q && (in_dir != dsfe_pkg::DIR_FORWARD) && (in_dir != dsfe_pkg::DIR_REVERSE);
  end

  // Failsafe timer
  logic        accept, upd;
  logic [31:0] fs_start_q, fs_start_d, elapsed;
  logic        fs_timing_q, fs_timing_d;
  logic        fs_exp_q, fs_exp_d;
  logic        force_zero;

  assign accept     = in_valid_i && in_ready_o;
  assign upd        = accept && (dsfe_pkg::op_e'(in_op_i) == dsfe_pkg::OP_THROTTLE);
  assign elapsed    = in_now - fs_start_q;
  assign force_zero = in_fs && fs_timing_q &&
                      (fs_exp_q || (elapsed > 32'(FAILSAFE_TIMEOUT_US)));

  always_comb begin
    fs_start_d  = fs_start_q;
    fs_timing_d = fs_timing_q;
    fs_exp_d    = fs_exp_q;
    if (upd) begin
      if (in_fs) begin
        if (!fs_timing_q) begin
          fs_start_d  = in_now;
          fs_timing_d = 1'b1;
          fs_exp_d    = 1'b0;
        end
      end else begin
        fs_timing_d = 1'b0;
        fs_exp_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_start_q  <= '0;
      fs_timing_q <= 1'b1;
      fs_exp_q    <= 1'b1;
    end else begin
      fs_start_q  <= fs_start_d;
      fs_timing_q <= fs_timing_d;
      fs_exp_q    <= fs_exp_d;
    end
  end

  // Stage 1 register: product and classification
  logic          s1_valid_q;
  dsfe_pkg::op_e s1_op_q;
  logic [1:0]    s1_idx_q;
  logic [VW-1:0] s1_cmd_q, s1_bmax_q, s1_base_q;
  logic [PW-1:0] s1_prod_q;
  logic          s1_zero_q;
  logic          s1_go, frame_req;

  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= dsfe_pkg::op_e'(in_op_i);
      s1_idx_q  <= in_idx;
      s1_cmd_q  <= in_cmd;
      s1_prod_q <= prod;
      s1_bmax_q <= bmax;
      s1_base_q <= base;
      s1_zero_q <= dir_bad || in_ground || force_zero;
    end
  end

  // Stage 2: clamp, add, build the packet
  logic [VW-1:0]                 scaled, value;
  logic [dsfe_pkg::PKT_W-1:0]    new_pkt;
  logic                          is_cmd;

  assign is_cmd = (s1_op_q == dsfe_pkg::OP_COMMAND);
  assign scaled = s1_prod_q[PW-1:10];

  always_comb begin
    value   = s1_zero_q ? '0 :
              s1_base_q + ((scaled < s1_bmax_q) ? scaled : s1_bmax_q);
    new_pkt = is_cmd ? build_packet(s1_cmd_q, 1'b1) : build_packet(value, 1'b0);
  end

  // Packet store and frame assembly
  logic [dsfe_pkg::LANES-1:0]                     st_valid_q, st_valid_d;
  logic [dsfe_pkg::LANES-1:0][dsfe_pkg::PKT_W-1:0] st_pkt_q;
  dsfe_pkg::frame_t                               frame;

  assign frame_req = is_cmd || (int'(s1_idx_q) == NUM_MOTORS - 1);
  assign s1_go     = s1_valid_q && (!frame_req || q_ready_i);
  assign q_push_o  = s1_go && frame_req;
  assign q_data_o  = frame;

  always_comb begin
    for (int m = 0; m < dsfe_pkg::LANES; m++) begin
      if (m < NUM_MOTORS && (is_cmd || s1_idx_q == 2'(m))) begin
        frame.valid[m] = 1'b1;
        frame.pkt[m]   = new_pkt;
      end else begin
        frame.valid[m] = st_valid_q[m];
        frame.pkt[m]   = st_pkt_q[m];
      end
    end
    st_valid_d = st_valid_q;
    if (s1_go) begin
      st_valid_d = frame_req ? '0 : frame.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      st_pkt_q <= frame.pkt;
    end
  end

endmodule

FILE: rtl/dsfe_queue.sv
// ----------------------------------------------------------------------------
// dsfe_queue
// Short frame queue decoupling the front from the slot serialiser.
// ----------------------------------------------------------------------------
module dsfe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dsfe_pkg::frame_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output dsfe_pkg::frame_t data_o,
  input  logic             pop_i
);

  localparam int DEPTH = dsfe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsfe_pkg::frame_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/dsfe_back.sv
// ----------------------------------------------------------------------------
// dsfe_back
// Slot serialiser: turns one frame into 48 pin-level beats, MSB first,
// with a registered output stage.
// ----------------------------------------------------------------------------
module dsfe_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  dsfe_pkg::frame_t                q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dsfe_pkg::LANES-1:0]      out_pins_o,
  output logic                            out_last_o
);

  localparam int BW = dsfe_pkg::BIT_IDX_W;

  logic                        act_q, act_d;
  dsfe_pkg::frame_t            fr_q;
  logic [BW-1:0]               bit_q, bit_d;
  dsfe_pkg::phase_e            ph_q, ph_d;
  logic                        ov_q, ov_d;
  logic [dsfe_pkg::LANES-1:0]  pins_q, pins_d, slot;
  logic                        last_q, last_d;
  logic                        adv, fin, load;

  assign adv     = act_q && (!ov_q || out_ready_i);
  assign fin     = adv && (bit_q == BW'(dsfe_pkg::PKT_W - 1)) && (ph_q == dsfe_pkg::PH_LOW);
  assign load    = (!act_q || fin) && q_valid_i;
  assign q_pop_o = load;

  // Pin levels of the current slot
  always_comb begin
    unique case (ph_q)
      dsfe_pkg::PH_HIGH: slot = fr_q.valid;
      dsfe_pkg::PH_DATA: begin
        for (int m = 0; m < dsfe_pkg::LANES; m++) begin
          slot[m] = fr_q.valid[m] && fr_q.pkt[m][~bit_q];
        end
      end
      default:           slot = '0;
    endcase
  end

  // Slot sequencing and output register
  always_comb begin
    act_d  = act_q;
    bit_d  = bit_q;
    ph_d   = ph_q;
    ov_d   = ov_q;
    pins_d = pins_q;
    last_d = last_q;
    if (adv) begin
      ov_d   = 1'b1;
      pins_d = slot;
      last_d = fin;
      unique case (ph_q)
        dsfe_pkg::PH_HIGH: ph_d = dsfe_pkg::PH_DATA;
        dsfe_pkg::PH_DATA: ph_d = dsfe_pkg::PH_LOW;
        default: begin
          ph_d  = dsfe_pkg::PH_HIGH;
          bit_d = bit_q + 1'b1;
        end
      endcase
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      act_d = 1'b1;
      bit_d = '0;
      ph_d  = dsfe_pkg::PH_HIGH;
    end else if (fin) begin
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      bit_q <= '0;
      ph_q  <= dsfe_pkg::PH_HIGH;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      bit_q <= bit_d;
      ph_q  <= ph_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pins_q <= pins_d;
    last_q <= last_d;
    if (load) begin
      fr_q <= q_data_i;
    end
  end

  assign out_valid_o = ov_q;
  assign out_pins_o  = pins_q;
  assign out_last_o  = last_q;

endmodule

FILE: rtl/dshot_four_motor_frame_encoder.sv
// ----------------------------------------------------------------------------
// dshot_four_motor_frame_encoder
// Four-motor DShot frame encoder: throttle mapping, packet framing and
// pin-slot serialisation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per beat: tuser is the opcode (throttle
//   update or command to all motors), tdata the packed item fields. A
//   throttle update for the last motor, or any command, closes a frame.
//   Master stream gives one beat per pin slot: tdata[3:0] are the four
//   motor pin levels, tlast marks the 48th slot of a frame.
//   Throughput: items that close no frame are taken one per cycle; a frame
//   is 48 output beats, one slot per cycle unless the master side stalls. A
//   two-entry frame queue lets the front keep accepting while a frame is
//   being shifted out; the front stalls only when that queue is full.
//   Path: after the closing item is accepted, its frame passes the stage-1
//   register, queue write, serialiser load and output register to the pins.
//   Reset: packet store emptied, idle offset 30, bidirectional mode on,
//   failsafe timer held as expired until failsafe is once seen inactive.
//   A stalled master side holds the current beat; the frame in progress
//   waits, and the queue and front back up behind it.
//   Configuration: write port, index 0 idle offset, index 1 mode.
// ----------------------------------------------------------------------------
module dshot_four_motor_frame_encoder #(
  parameter int NUM_MOTORS          = dsfe_pkg::NUM_MOTORS_DEF,
  parameter int FAILSAFE_TIMEOUT_US = dsfe_pkg::FAILSAFE_TIMEOUT_US_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsfe_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [dsfe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // motor_index[1:0], throttle[11:2], direction[13:12], on_ground[14],
  // failsafe_active[15], now_us[47:16], command_value[58:48], zero above
  input  logic [dsfe_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // opcode
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pin_levels[3:0], zero above
  output logic [dsfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  logic                        q_push, q_ready, q_valid, q_pop;
  dsfe_pkg::frame_t            q_wdata, q_rdata;
  logic [dsfe_pkg::LANES-1:0]  pins;

  dsfe_front #(
    .NUM_MOTORS          (NUM_MOTORS),
    .FAILSAFE_TIMEOUT_US (FAILSAFE_TIMEOUT_US)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_op_i    (s_axis_tuser_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  dsfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  dsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pins_o  (pins),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = dsfe_pkg::OUT_DATA_W'(pins);

endmodule

FILE: rtl/dsfe_checker.sv
// ----------------------------------------------------------------------------
// dsfe_checker
// Port-level checks of the slot stream: frame length, slot shapes and
// beat holding under back-pressure.
// ----------------------------------------------------------------------------
module dsfe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [dsfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  localparam int SW = $clog2(dsfe_pkg::FRAME_SLOTS);

  logic                       out_acc;
  logic [SW-1:0]              slot_q;
  dsfe_pkg::phase_e           ph_q;
  logic [dsfe_pkg::LANES-1:0] high_q;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Track position of each accepted beat within its frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      ph_q   <= dsfe_pkg::PH_HIGH;
      high_q <= '0;
    end else if (out_acc) begin
      slot_q <= (slot_q == SW'(dsfe_pkg::FRAME_SLOTS - 1)) ? '0 : slot_q + 1'b1;
      unique case (ph_q)
        dsfe_pkg::PH_HIGH: begin
          ph_q   <= dsfe_pkg::PH_DATA;
          high_q <= m_axis_tdata_o[dsfe_pkg::LANES-1:0];
        end
        dsfe_pkg::PH_DATA: ph_q <= dsfe_pkg::PH_LOW;
        default:           ph_q <= dsfe_pkg::PH_HIGH;
      endcase
    end
  end

  // Stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // tlast on exactly every 48th beat
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast_o == (slot_q == SW'(dsfe_pkg::FRAME_SLOTS - 1))))
    else $error("tlast not on the final slot of a frame");

  // Third slot of each bit is low on all pins
  a_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (ph_q == dsfe_pkg::PH_LOW) |-> (m_axis_tdata_o == '0))
    else $error("low slot carries a high pin");

  // Data slot only raises pins that were high in the leading slot
  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (ph_q == dsfe_pkg::PH_DATA) |->
      ((m_axis_tdata_o[dsfe_pkg::LANES-1:0] & ~high_q) == '0))
    else $error("data slot raises a pin of an idle motor");

endmodule

bind dshot_four_motor_frame_encoder dsfe_checker u_dsfe_checker (.*);
